// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
`default_nettype none
package i2cm_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT   = 2'd1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd4;
  localparam logic [7:0]  ACK_LIMIT_RST   = 8'd250;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_START     = 3'd1,
    OP_STOP      = 3'd2,
    OP_WRITE     = 3'd3,
    OP_READ      = 3'd4,
    OP_WAIT_ACK  = 3'd5,
    OP_SEND_ACK  = 3'd6,
    OP_SEND_NACK = 3'd7
  } op_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    op_e        cmd;
    logic       has_cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
  } out_item_t;

endpackage
`default_nettype wire

// ===== src/i2c_master_bit_engine_top.sv =====
// Top level of the I2C master bit engine.
// One transaction on the input channel is one bus tick, and every tick yields exactly one
// result transaction with the open-drain drive levels, busy/done flags, last read byte
// and last ack status. The engine takes one tick per clock cycle sustained while the output
// is not stalled; a tick's result passes through the input register, the tick queue and the
// engine output register. Phase length and ack timeout are set through the config port, which
// is always ready and must only be written while no tick is in flight. Index 0 is the
// phase length in ticks (0 acts as 1), index 1 the ack poll limit; other indexes are ignored.
`default_nettype none
module i2c_master_bit_engine_top
  import i2cm_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic  push;
  tick_t push_data;
  logic  full;
  logic  pop;
  logic  tick_valid;
  tick_t tick;

  assign cfg_ready_o = 1'b1;

  i2cm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  i2cm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (tick_valid),
    .pop_data_o  (tick)
  );

  i2cm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (tick_valid),
    .tick_i       (tick),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
`default_nettype wire

// ===== src/i2cm_front.sv =====
// Input stage: accepts ticks, decodes the command code, feeds the queue.
`default_nettype none
module i2cm_front
  import i2cm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_item_i,
  output logic          push_o,
  output tick_t         push_data_o,
  input  wire logic     full_i
);

  logic  valid_q;
  tick_t tick_q;
  tick_t tick_d;
  logic  accept;

  always_comb begin
    tick_d.cmd     = op_e'(in_item_i.operation);
    tick_d.has_cmd = (in_item_i.operation != OP_NONE);
    tick_d.tx_byte = in_item_i.tx_byte;
    tick_d.sda_in  = in_item_i.sda_in;
  end

  assign push_o      = valid_q && !full_i;
  assign in_stall_o  = valid_q && full_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = tick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tick_q <= tick_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/i2cm_queue.sv =====
// Small FIFO of decoded ticks between the input stage and the engine.
`default_nettype none
module i2cm_queue
  import i2cm_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire tick_t push_data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       valid_o,
  output tick_t      pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  tick_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (count_q == FullCnt);
  assign valid_o    = (count_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/i2cm_engine.sv =====
// Bus sequencer: runs line phases one tick per step, holds config and result register.
`default_nettype none
module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  tick_valid_i,
  input  wire tick_t                 tick_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_item_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_ST_A, S_ST_B, S_ST_C, S_SP_A, S_SP_B, S_SP_C,
    S_WR_D, S_WR_H, S_WR_L, S_RD_H, S_RD_S, S_RD_L,
    S_WA_R, S_WA_H, S_WA_P, S_WA_L, S_AK_A, S_AK_H, S_AK_L,
    S_NK_A, S_NK_H, S_NK_L
  } state_e;

  logic [15:0] phase_ticks_q;
  logic [7:0]  ack_limit_q;

  state_e      state_q, state_d, target;
  logic [15:0] phase_q, phase_d, phase_load;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  poll_q, poll_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        ack_q, ack_d;
  logic [7:0]  rx_q, rx_d;
  logic        done;
  logic        go;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        step;

  assign step        = tick_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o       = step;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign phase_load  = (phase_ticks_q == '0) ? '0 : phase_ticks_q - 16'd1;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    poll_d  = poll_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    done    = 1'b0;
    go      = 1'b0;
    target  = S_IDLE;

    if (state_q == S_IDLE) begin
      go = tick_i.has_cmd;
      unique case (tick_i.cmd)
        OP_START:     target = S_ST_A;
        OP_STOP:      target = S_SP_A;
        OP_WRITE: begin
          shift_d = tick_i.tx_byte;
          bit_d   = '0;
          target  = S_WR_D;
        end
        OP_READ: begin
          shift_d = '0;
          bit_d   = '0;
          target  = S_RD_H;
        end
        OP_WAIT_ACK: begin
          poll_d = '0;
          target = S_WA_R;
        end
        OP_SEND_ACK:  target = S_AK_A;
        OP_SEND_NACK: target = S_NK_A;
        default:      target = S_IDLE;
      endcase
    end else if (state_q == S_WA_P) begin
      if (!tick_i.sda_in) begin
        go     = 1'b1;
        target = S_WA_L;
      end else if (poll_q >= ack_limit_q) begin
        ack_d  = 1'b0;
        go     = 1'b1;
        target = S_SP_A;
      end else begin
        poll_d = poll_q + 8'd1;
      end
    end else if (phase_q != '0) begin
      phase_d = phase_q - 16'd1;
    end else begin
      go = 1'b1;
      unique case (state_q)
        S_ST_A: target = S_ST_B;
        S_ST_B: target = S_ST_C;
        S_SP_A: target = S_SP_B;
        S_SP_B: target = S_SP_C;
        S_WR_D: target = S_WR_H;
        S_WR_H: target = S_WR_L;
        S_WR_L: begin
          if (bit_q != 3'd7) begin
            bit_d  = bit_q + 3'd1;
            target = S_WR_D;
          end else begin
            go = 1'b0;
          end
        end
        S_RD_H: target = S_RD_S;
        S_RD_S: target = S_RD_L;
        S_RD_L: begin
          if (bit_q != 3'd7) begin
            bit_d  = bit_q + 3'd1;
            target = S_RD_H;
          end else begin
            rx_d = shift_q;
            go   = 1'b0;
          end
        end
        S_WA_R: target = S_WA_H;
        S_WA_H: target = S_WA_P;
        S_WA_L: begin
          ack_d = 1'b1;
          go    = 1'b0;
        end
        S_AK_A: target = S_AK_H;
        S_AK_H: target = S_AK_L;
        S_AK_L: begin
          sda_d = 1'b1;
          go    = 1'b0;
        end
        S_NK_A: target = S_NK_H;
        S_NK_H: target = S_NK_L;
        default: go = 1'b0;
      endcase
      if (!go) begin
        state_d = S_IDLE;
        phase_d = '0;
        done    = 1'b1;
      end
    end

    if (go) begin
      state_d = target;
      phase_d = phase_load;
      unique case (target)
        S_ST_A: begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        S_ST_B, S_SP_A, S_AK_A: sda_d = 1'b0;
        S_ST_C, S_WR_L, S_RD_L, S_WA_L, S_AK_L, S_NK_L: scl_d = 1'b0;
        S_SP_B, S_WR_H, S_AK_H, S_NK_H, S_WA_H: scl_d = 1'b1;
        S_SP_C, S_WA_R, S_NK_A: sda_d = 1'b1;
        S_WR_D: begin
          sda_d   = shift_d[7];
          shift_d = {shift_d[6:0], 1'b0};
        end
        S_RD_H: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          shift_d = {shift_d[6:0], 1'b0};
        end
        S_RD_S: shift_d = {shift_d[7:1], shift_d[0] | tick_i.sda_in};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PHASE_TICKS_RST;
      ack_limit_q   <= ACK_LIMIT_RST;
      state_q       <= S_IDLE;
      phase_q       <= '0;
      bit_q         <= '0;
      shift_q       <= '0;
      poll_q        <= '0;
      scl_q         <= 1'b1;
      sda_q         <= 1'b1;
      ack_q         <= 1'b0;
      rx_q          <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_PHASE_TICKS: phase_ticks_q <= cfg_data_i;
          CFG_ACK_LIMIT:   ack_limit_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (step) begin
        state_q        <= state_d;
        phase_q        <= phase_d;
        bit_q          <= bit_d;
        shift_q        <= shift_d;
        poll_q         <= poll_d;
        scl_q          <= scl_d;
        sda_q          <= sda_d;
        ack_q          <= ack_d;
        rx_q           <= rx_d;
        out_valid_q    <= 1'b1;
        out_q.scl_out  <= scl_d;
        out_q.sda_out  <= sda_d;
        out_q.busy_res <= (state_d != S_IDLE);
        out_q.done_res <= done;
        out_q.rx_byte  <= rx_d;
        out_q.ack_ok   <= ack_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/i2cm_checker.sv =====
// Port-level checker for the I2C master bit engine, bound to the top level.
`default_nettype none
module i2cm_checker
  import i2cm_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_stall_o,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o,
  input wire logic      cfg_ready_o
);

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.done_res |-> !out_item_o.busy_res)
    else $error("done reported while still busy");

  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o) || out_valid_o)
    else $error("input stalled with empty output side");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind i2c_master_bit_engine_top i2cm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
